// ===== rtl/core/lstra_pkg.sv =====
// Shared types and constants for the lazy segment tree range-add block.
// Depends on nothing; used by lstra_ctrl, lstra_dp and the top level.
package lstra_pkg;

	localparam int LEAVES    = 1024;
	localparam int LOG       = $clog2(LEAVES);
	localparam int SPAN      = 1 << LOG;
	localparam int MEM_DEPTH = 2 * SPAN;
	localparam int AW        = LOG + 1;
	localparam int NW        = LOG + 2;
	localparam int POS_W     = 11;
	localparam int VAL_W     = 32;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_QUERY = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN,
		ST_SCAN,
		ST_RMW
	} state_t;

	typedef struct packed {
		logic init;
		logic rd_walk;
		logic rd_lo;
		logic rd_hi;
		logic shift;
		logic wr_add;
		logic wr_leaf;
		logic clr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_act;
		logic       in_pos_ok;
		logic [1:0] act;
		logic       walk_top;
		logic       l_odd;
		logic       r_odd;
		logic       lr_empty;
		logic       clr_done;
	} stat_t;

endpackage

// ===== rtl/core/lstra_dp.sv =====
// Datapath: node memory, walk/range address registers, path accumulator.
// Driven by lstra_ctrl through cmd_t; depends on lstra_pkg.
module lstra_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lstra_pkg::cmd_t                   cmd,
	output lstra_pkg::stat_t                  stat,
	input  logic [1:0]                        action,
	input  logic [lstra_pkg::POS_W-1:0]       position,
	input  logic [lstra_pkg::POS_W-1:0]       range_end,
	input  logic [lstra_pkg::VAL_W-1:0]       amount,
	output logic                              done,
	output logic [lstra_pkg::VAL_W-1:0]       leaf_value
);
	import lstra_pkg::*;

	// internal nodes hold pending adds, leaf nodes hold value minus ancestor adds
	logic [VAL_W-1:0] mem [0:MEM_DEPTH-1];

	logic [VAL_W-1:0] rdata_q, acc_q, amt_q, leaf_value_q;
	logic [AW-1:0]    walk_a_q, tgt_q, leaf_q, clr_a_q;
	logic [NW-1:0]    l_q, r_q, r_m1;
	logic [1:0]       act_q;
	logic             rd_vld_s1, done_q;

	logic [31:0]      pos32, end32, leaf32, lpos32, rpos32, l32, r32;
	logic             pos_ok;
	logic             rd_en, we;
	logic [AW-1:0]    rd_a, wa;
	logic [VAL_W-1:0] wd;

	always_comb begin
		pos32  = {{(32-POS_W){1'b0}}, position};
		end32  = {{(32-POS_W){1'b0}}, range_end};
		pos_ok = (pos32 >= 32'd1) && (pos32 <= 32'(LEAVES));
		leaf32 = 32'(SPAN) + pos32 - 32'd1;
		lpos32 = (pos32 == 32'd0) ? 32'd1 : pos32;
		rpos32 = (end32 > 32'(LEAVES)) ? 32'(LEAVES) : end32;
		l32    = 32'(SPAN) + lpos32 - 32'd1;
		r32    = 32'(SPAN) + rpos32;
		r_m1   = r_q - NW'(1);
	end

	assign rd_en = cmd.rd_walk | cmd.rd_lo | cmd.rd_hi;
	assign we    = cmd.clr | cmd.wr_add | cmd.wr_leaf;

	always_comb begin
		if (cmd.rd_walk) begin
			rd_a = walk_a_q;
		end else if (cmd.rd_lo) begin
			rd_a = l_q[AW-1:0];
		end else begin
			rd_a = r_m1[AW-1:0];
		end
		if (cmd.clr) begin
			wa = clr_a_q;
			wd = '0;
		end else if (cmd.wr_add) begin
			wa = tgt_q;
			wd = rdata_q + amt_q;
		end else begin
			wa = leaf_q;
			wd = amt_q - acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			clr_a_q   <= '0;
			done_q    <= 1'b0;
			act_q     <= ACT_LOAD;
		end else begin
			rd_vld_s1 <= cmd.rd_walk;
			done_q    <= cmd.emit;
			if (cmd.clr) begin
				clr_a_q <= clr_a_q + AW'(1);
			end
			if (cmd.init) begin
				act_q <= action;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_a];
		end
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.emit) begin
			leaf_value_q <= acc_q;
		end
		if (cmd.init) begin
			acc_q  <= '0;
			amt_q  <= amount;
			leaf_q <= leaf32[AW-1:0];
			l_q    <= l32[NW-1:0];
			r_q    <= r32[NW-1:0];
			if (act_t'(action) == ACT_QUERY) begin
				walk_a_q <= leaf32[AW-1:0];
			end else begin
				walk_a_q <= leaf32[AW:1];
			end
		end else begin
			if (rd_vld_s1) begin
				acc_q <= acc_q + rdata_q;
			end
			if (cmd.rd_walk) begin
				walk_a_q <= walk_a_q >> 1;
			end
			if (cmd.rd_lo) begin
				tgt_q <= l_q[AW-1:0];
				l_q   <= l_q + NW'(1);
			end
			if (cmd.rd_hi) begin
				tgt_q <= r_m1[AW-1:0];
				r_q   <= r_m1;
			end
			if (cmd.shift) begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
		end
	end

	always_comb begin
		stat.in_act    = action;
		stat.in_pos_ok = pos_ok;
		stat.act       = act_q;
		stat.walk_top  = (walk_a_q == AW'(1));
		stat.l_odd     = l_q[0];
		stat.r_odd     = r_q[0];
		stat.lr_empty  = (l_q >= r_q);
		stat.clr_done  = (clr_a_q == AW'(MEM_DEPTH - 1));
	end

	assign done       = done_q;
	assign leaf_value = leaf_value_q;

	// single-port style: never read and write in one cycle
	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && rd_en))
		else $error("read and write in same cycle");

	// a node add always follows its own read
	a_rmw_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_add |-> $past(cmd.rd_lo || cmd.rd_hi))
		else $error("node add without prior read");

	// node zero is unused outside the clearing pass
	a_no_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(we && !cmd.clr) |-> (wa != '0))
		else $error("write to node zero");

endmodule

// ===== rtl/core/lstra_ctrl.sv =====
// Controller FSM: clearing pass, path walk for load/query, bottom-up range add.
// Issues cmd_t to lstra_dp and reads back stat_t; depends on lstra_pkg.
module lstra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lstra_pkg::stat_t  stat,
	output lstra_pkg::cmd_t   cmd
);
	import lstra_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					case (act_t'(stat.in_act))
						ACT_LOAD:  state_d = stat.in_pos_ok ? ST_WALK : ST_IDLE;
						ACT_QUERY: state_d = stat.in_pos_ok ? ST_WALK : ST_FIN;
						ACT_ADD:   state_d = ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				cmd.rd_walk = 1'b1;
				if (stat.walk_top) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (act_t'(stat.act) == ACT_QUERY) begin
					cmd.emit = 1'b1;
				end else begin
					cmd.wr_leaf = 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.lr_empty) begin
					state_d = ST_IDLE;
				end else if (stat.l_odd) begin
					cmd.rd_lo = 1'b1;
					state_d   = ST_RMW;
				end else if (stat.r_odd) begin
					cmd.rd_hi = 1'b1;
					state_d   = ST_RMW;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_RMW: begin
				cmd.wr_add = 1'b1;
				state_d    = ST_SCAN;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// a result only comes out of a query's final step
	a_emit_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (act_t'(stat.act) == ACT_QUERY && state_q == ST_FIN))
		else $error("result outside query");

	// clearing pass runs only out of reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> ($past(state_q) == ST_CLEAR))
		else $error("re-entered clearing pass");

	// a new transaction is never taken while busy
	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |-> !busy)
		else $error("transaction taken while busy");

endmodule

// ===== rtl/core/lazy_segment_tree_range_add.sv =====
// Top level of the lazy segment tree with range add and point query.
// Instantiates lstra_ctrl and lstra_dp; depends on lstra_pkg.
//
//  channel   handshake              fields
//  command   start & !busy          action, position, range_end, amount
//  result    done (one cycle)       leaf_value
//
// After reset the node memory is cleared, one node per cycle, while busy is high.
// Load: 10 ancestor reads, a drain step and a leaf write; query: 11 reads
// (leaf to root), a drain step, then done in the cycle in which busy falls.
// Range add: a read and then a write for each marked node, a shift step for
// each level climbed, until the range bounds meet.
// Results cannot be stalled; done marks leaf_value for exactly one cycle.
module lazy_segment_tree_range_add (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [lstra_pkg::POS_W-1:0]  position,
	input  logic [lstra_pkg::POS_W-1:0]  range_end,
	input  logic [lstra_pkg::VAL_W-1:0]  amount,
	output logic                         done,
	output logic [lstra_pkg::VAL_W-1:0]  leaf_value
);
	import lstra_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lstra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lstra_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.position   (position),
		.range_end  (range_end),
		.amount     (amount),
		.done       (done),
		.leaf_value (leaf_value)
	);

endmodule
